/* hdl/host_supervisor_watchdog_defines.svh */
// Assertion macros for the host supervisor watchdog checker
`ifndef HOST_SUPERVISOR_WATCHDOG_DEFINES_SVH
`define HOST_SUPERVISOR_WATCHDOG_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while in reset
`define HSW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hsw: same-cycle check failed");

// Next-cycle implication, clocked on aclk, off while in reset
`define HSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hsw: next-cycle check failed");

`endif

/* hdl/hsw_pkg.sv */
// Types, codes and constants of the host supervisor watchdog
package hsw_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned HOLD_W = 13;
    localparam int unsigned EVENT_W = 4;
    localparam int unsigned STEP_W = 3;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_STATUS      = 4'd0;
    localparam logic [EVENT_W-1:0] EV_IGN_OFF     = 4'd1;
    localparam logic [EVENT_W-1:0] EV_REBOOT      = 4'd2;
    localparam logic [EVENT_W-1:0] EV_POWER_ON    = 4'd3;
    localparam logic [EVENT_W-1:0] EV_KEY_PRESS   = 4'd4;
    localparam logic [EVENT_W-1:0] EV_KEY_RELEASE = 4'd5;
    localparam logic [EVENT_W-1:0] EV_VERSION     = 4'd6;
    localparam logic [EVENT_W-1:0] EV_FEED_ACK    = 4'd7;
    localparam logic [EVENT_W-1:0] EV_START_ACK   = 4'd8;
    localparam logic [EVENT_W-1:0] EV_JUMP_BOOT   = 4'd9;

    // Host command codes
    localparam logic [1:0] CMD_VERSION   = 2'd0;
    localparam logic [1:0] CMD_FEED      = 2'd1;
    localparam logic [1:0] CMD_JUMP_BOOT = 2'd2;
    localparam logic [1:0] CMD_RUN_APP   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_DEFAULT_LIMIT = 2'd0;
    localparam logic [1:0] REG_BOOT_VER      = 2'd1;
    localparam logic [1:0] REG_APP_VER       = 2'd2;

    // Reset values
    localparam logic [WORD_W-1:0] DEFAULT_LIMIT_RST = 32'd30;
    localparam logic [WORD_W-1:0] BOOT_VER_RST      = 32'h0403_0201;
    localparam logic [WORD_W-1:0] APP_VER_RST       = 32'h0100_0104;

    // Power-cycle hold times
    localparam logic [HOLD_W-1:0] HOLD_REBOOT_MS   = 13'd5000;
    localparam logic [HOLD_W-1:0] HOLD_POWER_ON_MS = 13'd2000;
    localparam logic [HOLD_W-1:0] HOLD_KEY_MS      = 13'd3000;
    localparam logic [HOLD_W-1:0] HOLD_NONE_MS     = 13'd0;

    typedef struct packed {
        logic              ignition_on;
        logic              cmd_valid;
        logic [1:0]        command;
        logic [WORD_W-1:0] new_start_delay;
        logic [WORD_W-1:0] new_feed_timeout;
    } hsw_in_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [WORD_W-1:0]  word_a;
        logic [WORD_W-1:0]  word_b;
        logic               rails_on;
        logic               key_released;
        logic [HOLD_W-1:0]  hold_ms;
        logic               last;
    } hsw_out_t;

    // Results owed for one item: optional ignition-off report or power cycle,
    // then one closing result
    typedef struct packed {
        logic               ign_off;
        logic               power_cycle;
        logic [WORD_W-1:0]  ign_word_a;
        logic [WORD_W-1:0]  ign_word_b;
        logic [EVENT_W-1:0] tail_event;
        logic [WORD_W-1:0]  tail_word_a;
        logic [WORD_W-1:0]  tail_word_b;
    } hsw_plan_t;

endpackage

/* hdl/hsw_core.sv */
// Counters, limits and configuration registers; builds the result plan per item
module hsw_core
    import hsw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [WORD_W-1:0] cfg_wdata,
    input  logic              item_accept,
    input  hsw_in_t           item,
    output hsw_plan_t         plan
);

    logic [WORD_W-1:0] default_limit_reg;
    logic [WORD_W-1:0] boot_ver_reg;
    logic [WORD_W-1:0] app_ver_reg;
    logic [WORD_W-1:0] grace_reg, grace_next;
    logic [WORD_W-1:0] feed_reg, feed_next;
    logic [WORD_W-1:0] start_delay_reg, start_delay_next;
    logic [WORD_W-1:0] feed_timeout_reg, feed_timeout_next;

    logic              below_grace;
    logic              cycle_hit;
    logic [WORD_W-1:0] grace_ign;
    logic [WORD_W-1:0] feed_ign;
    logic [WORD_W-1:0] sd_eff;
    logic [WORD_W-1:0] ft_eff;

    always_comb begin
        below_grace = grace_reg < start_delay_reg;
        sd_eff = (item.new_start_delay == '0) ? default_limit_reg : item.new_start_delay;
        ft_eff = (item.new_feed_timeout == '0) ? default_limit_reg : item.new_feed_timeout;

        // Compare against the pre-increment count so no add sits before the compare
        if (below_grace || (&feed_reg)) begin
            cycle_hit = feed_reg > feed_timeout_reg;
        end else begin
            cycle_hit = feed_reg >= feed_timeout_reg;
        end

        grace_ign = grace_reg;
        feed_ign  = feed_reg;
        if (below_grace) begin
            grace_ign = grace_reg + 32'd1;
        end else if (!(&feed_reg)) begin
            feed_ign = feed_reg + 32'd1;
        end

        plan = '0;
        start_delay_next  = start_delay_reg;
        feed_timeout_next = feed_timeout_reg;

        if (item.ignition_on) begin
            if (cycle_hit) begin
                plan.power_cycle = 1'b1;
                grace_next = '0;
                feed_next  = '0;
            end else begin
                grace_next = grace_ign;
                feed_next  = feed_ign;
            end
        end else begin
            plan.ign_off    = 1'b1;
            plan.ign_word_a = feed_reg;
            plan.ign_word_b = grace_reg;
            grace_next = grace_reg;
            feed_next  = feed_reg;
        end

        if (item.cmd_valid) begin
            unique case (item.command)
                CMD_VERSION: begin
                    plan.tail_event  = EV_VERSION;
                    plan.tail_word_a = boot_ver_reg;
                    plan.tail_word_b = app_ver_reg;
                end
                CMD_FEED: begin
                    start_delay_next  = sd_eff;
                    feed_timeout_next = ft_eff;
                    feed_next         = '0;
                    plan.tail_event   = EV_FEED_ACK;
                    plan.tail_word_a  = ft_eff;
                    plan.tail_word_b  = sd_eff;
                end
                CMD_JUMP_BOOT: begin
                    plan.tail_event = EV_JUMP_BOOT;
                end
                CMD_RUN_APP: begin
                    plan.tail_event = EV_START_ACK;
                end
                default: begin
                    plan.tail_event = EV_START_ACK;
                end
            endcase
        end else begin
            plan.tail_event  = EV_STATUS;
            plan.tail_word_a = feed_next;
            plan.tail_word_b = grace_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_limit_reg <= DEFAULT_LIMIT_RST;
            boot_ver_reg      <= BOOT_VER_RST;
            app_ver_reg       <= APP_VER_RST;
            grace_reg         <= '0;
            feed_reg          <= '0;
            start_delay_reg   <= DEFAULT_LIMIT_RST;
            feed_timeout_reg  <= DEFAULT_LIMIT_RST;
        end else begin
            if (cfg_wr_en) begin
                // Index three is not a register: drop the write
                unique case (cfg_index)
                    REG_DEFAULT_LIMIT: default_limit_reg <= cfg_wdata;
                    REG_BOOT_VER:      boot_ver_reg      <= cfg_wdata;
                    REG_APP_VER:       app_ver_reg       <= cfg_wdata;
                    default: ;
                endcase
            end
            if (item_accept) begin
                grace_reg        <= grace_next;
                feed_reg         <= feed_next;
                start_delay_reg  <= start_delay_next;
                feed_timeout_reg <= feed_timeout_next;
            end
        end
    end

endmodule

/* hdl/hsw_emit.sv */
// Plan and result registers emit an item's results one per cycle unless stalled
module hsw_emit
    import hsw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      plan_load,
    input  hsw_plan_t plan_in,
    output logic      plan_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output hsw_out_t  m_data
);

    hsw_plan_t         plan_reg;
    logic              plan_valid_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_valid_reg;
    hsw_out_t          m_data_reg;

    logic              out_load;
    logic [STEP_W-1:0] final_step;
    logic              plan_done;
    hsw_out_t          result;

    always_comb begin
        if (plan_reg.power_cycle) begin
            final_step = 3'd4;
        end else if (plan_reg.ign_off) begin
            final_step = 3'd1;
        end else begin
            final_step = 3'd0;
        end

        out_load   = plan_valid_reg && (!m_valid_reg || m_ready);
        plan_done  = out_load && (step_reg == final_step);
        plan_ready = !plan_valid_reg || plan_done;

        result              = '0;
        result.rails_on     = 1'b1;
        result.key_released = 1'b1;
        result.hold_ms      = HOLD_NONE_MS;
        result.last         = step_reg == final_step;

        if (plan_reg.power_cycle && !step_reg[2]) begin
            unique case (step_reg[1:0])
                2'd0: begin
                    result.event_res = EV_REBOOT;
                    result.rails_on  = 1'b0;
                    result.hold_ms   = HOLD_REBOOT_MS;
                end
                2'd1: begin
                    result.event_res = EV_POWER_ON;
                    result.hold_ms   = HOLD_POWER_ON_MS;
                end
                2'd2: begin
                    result.event_res    = EV_KEY_PRESS;
                    result.key_released = 1'b0;
                    result.hold_ms      = HOLD_KEY_MS;
                end
                default: begin
                    result.event_res = EV_KEY_RELEASE;
                end
            endcase
        end else if (plan_reg.ign_off && (step_reg == '0)) begin
            result.event_res = EV_IGN_OFF;
            result.word_a    = plan_reg.ign_word_a;
            result.word_b    = plan_reg.ign_word_b;
        end else begin
            result.event_res = plan_reg.tail_event;
            result.word_a    = plan_reg.tail_word_a;
            result.word_b    = plan_reg.tail_word_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_valid_reg <= 1'b0;
            step_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (plan_load) begin
                plan_valid_reg <= 1'b1;
                step_reg       <= '0;
            end else if (plan_done) begin
                plan_valid_reg <= 1'b0;
            end else if (out_load) begin
                step_reg <= step_reg + 3'd1;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (plan_load) begin
            plan_reg <= plan_in;
        end
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hdl/host_supervisor_watchdog.sv */
// Host supervisor watchdog: grace and feed counters with power-cycle sequencing
//
// Input channel s_valid/s_ready/s_data carries one supervisor pass per
// transaction (ignition level and an optional host command). Result channel
// m_valid/m_ready/m_data returns one, two or five results per pass; the
// final one has last set. Configuration is a plain write port
// (cfg_wr_en, cfg_index, cfg_wdata): 0 default limit, 1 boot version,
// 2 app version; index 3 is ignored. Write it only while the block is idle.
// An accepted pass goes into the plan register, then its first result into the
// result register; the rest follow one per cycle while m_ready does not stall.
// The single result register sets the rate: with m_ready high, single-result
// passes are taken every cycle; a power-cycle pass holds the input to its end.
// Counters and limits update on the cycle a pass is accepted.
// Reset (aresetn low, synchronous) clears both counters, loads 30 into
// both limits and the registers' reset values, and empties the pipeline.
// A stall on m_ready holds the current result; once a pass's last result is
// loaded, the next pass is still taken into the plan register and waits there.
module host_supervisor_watchdog
    import hsw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hsw_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hsw_out_t          m_data,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [WORD_W-1:0] cfg_wdata
);

    hsw_plan_t plan;
    logic      plan_ready;
    logic      item_accept;

    assign s_ready     = plan_ready;
    assign item_accept = s_valid && plan_ready;

    hsw_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .item_accept (item_accept),
        .item        (s_data),
        .plan        (plan)
    );

    hsw_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .plan_load  (item_accept),
        .plan_in    (plan),
        .plan_ready (plan_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* hdl/hsw_checker.sv */
// Port-level checks of the host supervisor watchdog, bound to the top level
`include "host_supervisor_watchdog_defines.svh"

module hsw_checker
    import hsw_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input hsw_out_t m_data
);

    logic early_event;
    logic reboot_levels;

    assign early_event = (m_data.event_res == EV_IGN_OFF) || (m_data.event_res == EV_REBOOT)
                         || (m_data.event_res == EV_POWER_ON)
                         || (m_data.event_res == EV_KEY_PRESS)
                         || (m_data.event_res == EV_KEY_RELEASE);
    assign reboot_levels = !m_data.rails_on && m_data.key_released
                           && (m_data.hold_ms == HOLD_REBOOT_MS) && !m_data.last;

    // A stalled result transaction holds
    `HSW_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data))

    // Only the ignition-off report and power-cycle steps come before the final result
    `HSW_ASSERT_NOW(a_non_last_event, m_valid && !m_data.last, early_event)

    // Reboot drops the rails for five seconds and is never final
    `HSW_ASSERT_NOW(a_reboot_levels, m_valid && (m_data.event_res == EV_REBOOT), reboot_levels)

    // Power-on follows reboot in the very next cycle
    `HSW_ASSERT_NEXT(a_reboot_then_power_on, m_valid && m_ready && (m_data.event_res == EV_REBOOT), m_valid && (m_data.event_res == EV_POWER_ON))

endmodule

bind host_supervisor_watchdog hsw_checker u_hsw_checker (.*);
